@@ hdl/imu_motion_event_classifier_defines.svh @@
// Assertion macros for the IMU motion event classifier.
// They expect clk and arst_n in the scope that uses them; no other dependencies.
`ifndef IMU_MOTION_EVENT_CLASSIFIER_DEFINES_SVH
`define IMU_MOTION_EVENT_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define IMC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define IMC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/imc_pkg.sv @@
// Shared types and constants of the IMU motion event classifier.
// Used by the stream payloads, the controller, the datapath and the top level.
`default_nettype none

package imc_pkg;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_MOVE_DELTA   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHAKE_GYRO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PICKUP_DELTA = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_MS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STILL_MS     = 3'd4;

	localparam logic [15:0] RST_MOVE_DELTA   = 16'd328;
	localparam logic [15:0] RST_SHAKE_GYRO   = 16'd8192;
	localparam logic [15:0] RST_PICKUP_DELTA = 16'd1229;
	localparam logic [15:0] RST_COOLDOWN_MS  = 16'd800;
	localparam logic [23:0] RST_STILL_MS     = 24'd60000;

	// Event codes.
	localparam logic [2:0] EV_NONE   = 3'd0;
	localparam logic [2:0] EV_SHAKE  = 3'd1;
	localparam logic [2:0] EV_PICKUP = 3'd2;
	localparam logic [2:0] EV_MOTION = 3'd3;
	localparam logic [2:0] EV_STILL  = 3'd4;

	// Magnitude and axis selects for the shared square and root unit.
	localparam logic [1:0] MAG_ACCEL = 2'd0;
	localparam logic [1:0] MAG_GYRO  = 2'd1;
	localparam logic [1:0] MAG_PREV  = 2'd2;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// One root bit per step over a 32-bit sum of squares.
	localparam int ROOT_STEPS = 16;
	localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

	// 1 g in Q3.12.
	localparam logic [15:0] ONE_G_Q12 = 16'd4096;

	// floor(x / 5) = (x * DIV5_RECIP) >> DIV5_SHIFT, exact for x below 2^22.
	localparam logic [19:0] DIV5_RECIP = 20'd838861;
	localparam int          DIV5_SHIFT = 22;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
		logic        [31:0] now_ms;
		logic               restart;
	} imc_sample_t;

	typedef struct packed {
		logic [2:0] event_res;
	} imc_result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       acc_en;
		logic       acc_clr;
		logic       root_step;
		logic       mag_save;
		logic       commit;
		logic [1:0] mag_sel;
		logic [1:0] axis_sel;
	} imc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic short_path;
		logic out_busy;
	} imc_status_t;

endpackage

`default_nettype wire

@@ hdl/imc_stream_if.sv @@
// Valid/ready stream channel used for the sample and result words.
// The payload type is a parameter; no other dependencies.
`default_nettype none

interface imc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/imc_ctrl.sv @@
// Sequencing state machine of the IMU motion event classifier.
// Depends on imc_pkg for the command and status structs.
`default_nettype none

module imc_ctrl
	import imc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire imc_status_t status,
	output imc_cmd_t         cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_SQ       = 3'd2;
	localparam logic [2:0] S_ROOT     = 3'd3;
	localparam logic [2:0] S_SAVE     = 3'd4;
	localparam logic [2:0] S_DECIDE   = 3'd5;

	localparam logic [ROOT_CNT_W-1:0] ROOT_LAST = ROOT_CNT_W'(ROOT_STEPS - 1);

	logic [2:0]            state_q, state_d;
	logic [1:0]            mag_q;
	logic [1:0]            axis_q;
	logic [ROOT_CNT_W-1:0] bit_q;

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.mag_sel  = mag_q;
		cmd.axis_sel = axis_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = status.short_path ? S_DECIDE : S_SQ;
			end
			S_SQ: begin
				cmd.acc_en  = 1'b1;
				cmd.acc_clr = (axis_q == AXIS_X);
				if (axis_q == AXIS_Z) begin
					state_d = S_ROOT;
				end
			end
			S_ROOT: begin
				cmd.root_step = 1'b1;
				if (bit_q == ROOT_LAST) begin
					state_d = S_SAVE;
				end
			end
			S_SAVE: begin
				cmd.mag_save = 1'b1;
				state_d      = (mag_q == MAG_PREV) ? S_DECIDE : S_SQ;
			end
			S_DECIDE: begin
				if (!status.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mag_q   <= MAG_ACCEL;
			axis_q  <= AXIS_X;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_DISPATCH: begin
					mag_q  <= MAG_ACCEL;
					axis_q <= AXIS_X;
				end
				S_SQ: begin
					axis_q <= axis_q + 2'd1;
					bit_q  <= '0;
				end
				S_ROOT: begin
					bit_q <= bit_q + 1'b1;
				end
				S_SAVE: begin
					mag_q  <= mag_q + 2'd1;
					axis_q <= AXIS_X;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hdl/imc_datapath.sv @@
// Datapath of the IMU motion event classifier: sample and history registers,
// shared squarer and bit-serial square root, event decision and result register.
// Depends on imc_pkg for payload, command and status types and constants.
`default_nettype none

module imc_datapath
	import imc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire imc_cmd_t              cmd,
	output imc_status_t                status,
	input  wire imc_sample_t           sample_word,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output imc_result_t                out_word,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers.
	logic [15:0] move_delta_q;
	logic [15:0] shake_gyro_q;
	logic [15:0] pickup_delta_q;
	logic [15:0] cooldown_ms_q;
	logic [23:0] still_ms_q;

	// Latched sample.
	imc_sample_t smp_q;

	// History.
	logic signed [15:0] prev_x_q, prev_y_q, prev_z_q;
	logic               have_prev_q;
	logic        [31:0] last_motion_q;
	logic        [31:0] cool_until_q;
	logic               still_rep_q;

	// Arithmetic.
	logic        [31:0] acc_q;
	logic        [16:0] rem_q;
	logic        [15:0] root_q;
	logic        [15:0] amag_q, gmag_q, pmag_q;
	logic        [16:0] thr_q;
	logic               out_valid_q;
	logic        [2:0]  ev_q;

	logic signed [15:0] sq_op;
	logic signed [31:0] sq_full;
	logic        [18:0] rem_sh, trial, rem_sub;
	logic               root_ge;
	logic        [19:0] nine_md;
	logic        [39:0] thr_prod;

	logic        [16:0] mag_diff;
	logic        [15:0] mag_delta;
	logic        [17:0] axis_delta;
	logic        [15:0] g_dev;
	logic        [31:0] quiet;
	logic        [31:0] cool_next;
	logic               moved, cool_active, shake_hit, pick_hit, still_hit;
	logic        [2:0]  ev_d;

	function automatic logic [15:0] absdiff16(input logic signed [15:0] a,
		input logic signed [15:0] b);
		logic [16:0] d;
		d = {a[15], a} - {b[15], b};
		return d[16] ? 16'(-d) : d[15:0];
	endfunction

	// Square operand for the current magnitude and axis.
	always_comb begin
		sq_op = '0;
		case (cmd.mag_sel)
			MAG_ACCEL: begin
				case (cmd.axis_sel)
					AXIS_X:  sq_op = smp_q.accel_x;
					AXIS_Y:  sq_op = smp_q.accel_y;
					AXIS_Z:  sq_op = smp_q.accel_z;
					default: sq_op = '0;
				endcase
			end
			MAG_GYRO: begin
				case (cmd.axis_sel)
					AXIS_X:  sq_op = smp_q.gyro_x;
					AXIS_Y:  sq_op = smp_q.gyro_y;
					AXIS_Z:  sq_op = smp_q.gyro_z;
					default: sq_op = '0;
				endcase
			end
			MAG_PREV: begin
				case (cmd.axis_sel)
					AXIS_X:  sq_op = prev_x_q;
					AXIS_Y:  sq_op = prev_y_q;
					AXIS_Z:  sq_op = prev_z_q;
					default: sq_op = '0;
				endcase
			end
			default: sq_op = '0;
		endcase
	end

	assign sq_full = sq_op * sq_op;

	// One root bit per step: bring down two bits of the sum, try (root << 2) | 1.
	assign rem_sh  = {rem_q, acc_q[31:30]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign root_ge = (rem_sh >= trial);
	assign rem_sub = rem_sh - trial;

	// Axis threshold floor(9 * move_delta / 5).
	assign nine_md  = {1'b0, move_delta_q, 3'b000} + {4'd0, move_delta_q};
	assign thr_prod = nine_md * DIV5_RECIP;

	// Decision terms.
	assign mag_diff   = {1'b0, amag_q} - {1'b0, pmag_q};
	assign mag_delta  = mag_diff[16] ? 16'(-mag_diff) : mag_diff[15:0];
	assign axis_delta = {2'b00, absdiff16(smp_q.accel_x, prev_x_q)}
		+ {2'b00, absdiff16(smp_q.accel_y, prev_y_q)}
		+ {2'b00, absdiff16(smp_q.accel_z, prev_z_q)};
	assign g_dev      = (amag_q >= ONE_G_Q12) ? (amag_q - ONE_G_Q12) : (ONE_G_Q12 - amag_q);
	assign moved      = (mag_delta >= move_delta_q) || (axis_delta >= {1'b0, thr_q});
	assign cool_active = (smp_q.now_ms < cool_until_q);
	assign shake_hit  = (gmag_q >= shake_gyro_q);
	assign pick_hit   = (g_dev >= pickup_delta_q);
	assign quiet      = smp_q.now_ms - last_motion_q;
	assign still_hit  = !still_rep_q && (quiet >= {8'd0, still_ms_q});
	assign cool_next  = smp_q.now_ms + {16'd0, cooldown_ms_q};

	// Restart, first sample, cooldown: no event; else shake, pickup, motion, still long.
	always_comb begin
		if (smp_q.restart || !have_prev_q || cool_active) begin
			ev_d = EV_NONE;
		end else if (shake_hit) begin
			ev_d = EV_SHAKE;
		end else if (pick_hit) begin
			ev_d = EV_PICKUP;
		end else if (moved) begin
			ev_d = EV_MOTION;
		end else if (still_hit) begin
			ev_d = EV_STILL;
		end else begin
			ev_d = EV_NONE;
		end
	end

	assign status.short_path = smp_q.restart || !have_prev_q;
	assign status.out_busy   = out_valid_q && !out_ready;

	assign out_valid          = out_valid_q;
	assign out_word.event_res = ev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_delta_q   <= RST_MOVE_DELTA;
			shake_gyro_q   <= RST_SHAKE_GYRO;
			pickup_delta_q <= RST_PICKUP_DELTA;
			cooldown_ms_q  <= RST_COOLDOWN_MS;
			still_ms_q     <= RST_STILL_MS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MOVE_DELTA:   move_delta_q   <= cfg_data[15:0];
				REG_SHAKE_GYRO:   shake_gyro_q   <= cfg_data[15:0];
				REG_PICKUP_DELTA: pickup_delta_q <= cfg_data[15:0];
				REG_COOLDOWN_MS:  cooldown_ms_q  <= cfg_data[15:0];
				REG_STILL_MS:     still_ms_q     <= cfg_data[23:0];
				default: begin
				end
			endcase
		end
	end

	// Payload registers of the arithmetic.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			smp_q <= sample_word;
			thr_q <= thr_prod[DIV5_SHIFT+16:DIV5_SHIFT];
		end
		if (cmd.acc_en) begin
			acc_q <= (cmd.acc_clr ? 32'd0 : acc_q) + unsigned'(sq_full);
		end else if (cmd.root_step) begin
			acc_q <= {acc_q[29:0], 2'b00};
		end
		if (cmd.acc_en && cmd.acc_clr) begin
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rem_q  <= root_ge ? rem_sub[16:0] : rem_sh[16:0];
			root_q <= {root_q[14:0], root_ge};
		end
		if (cmd.mag_save) begin
			case (cmd.mag_sel)
				MAG_ACCEL: amag_q <= root_q;
				MAG_GYRO:  gmag_q <= root_q;
				MAG_PREV:  pmag_q <= root_q;
				default: begin
				end
			endcase
		end
	end

	// History and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q      <= '0;
			prev_y_q      <= '0;
			prev_z_q      <= '0;
			have_prev_q   <= 1'b0;
			last_motion_q <= '0;
			cool_until_q  <= '0;
			still_rep_q   <= 1'b0;
			out_valid_q   <= 1'b0;
			ev_q          <= EV_NONE;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.commit) begin
				ev_q <= ev_d;
				if (smp_q.restart) begin
					prev_x_q      <= '0;
					prev_y_q      <= '0;
					prev_z_q      <= '0;
					have_prev_q   <= 1'b0;
					last_motion_q <= smp_q.now_ms;
					cool_until_q  <= '0;
					still_rep_q   <= 1'b0;
				end else if (!have_prev_q) begin
					prev_x_q      <= smp_q.accel_x;
					prev_y_q      <= smp_q.accel_y;
					prev_z_q      <= smp_q.accel_z;
					have_prev_q   <= 1'b1;
					last_motion_q <= smp_q.now_ms;
				end else begin
					prev_x_q <= smp_q.accel_x;
					prev_y_q <= smp_q.accel_y;
					prev_z_q <= smp_q.accel_z;
					if (moved) begin
						last_motion_q <= smp_q.now_ms;
						still_rep_q   <= 1'b0;
					end else if (ev_d == EV_STILL) begin
						still_rep_q <= 1'b1;
					end
					if (ev_d inside {EV_SHAKE, EV_PICKUP, EV_MOTION}) begin
						cool_until_q <= cool_next;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/imu_motion_event_classifier.sv @@
// A restart or first sample goes from its dispatch state straight to the decision state;
// any other sample passes dispatch, three magnitudes on the shared squarer and
// one-bit-per-cycle square root, and the decision, which waits while the old word is held.
// New samples wait for the last commit; each such sample runs the 16-step root thrice.
// Reset: arst_n clears history, control and the result register, and loads register defaults.
`default_nettype none
`include "imu_motion_event_classifier_defines.svh"

// Top level. The sample channel is taken only while the controller is idle, so
// one sample is in work at a time. A finished result word sits in the datapath's
// output register; the next sample may be accepted while it waits, and the
// controller holds in its decision state only if the old word is still there
// when the new result is ready to be written.
//
// Configuration writes land directly in the datapath's registers. Writes with
// an index outside the register list are dropped.
module imu_motion_event_classifier
	import imc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	imc_stream_if.sink                 sample,
	imc_stream_if.source               result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	imc_cmd_t    cmd_w;
	imc_status_t status_w;
	imc_result_t result_word;

	// The controller walks each sample through dispatch, the three magnitude passes
	// (accel, gyro, previous accel; skipped for a restart or first sample) and the decision.
	imc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.status   (status_w),
		.cmd      (cmd_w)
	);

	// The datapath holds the sample, the history, the shared arithmetic and the
	// result register; it sees only the commands and reports back its status.
	imc_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_w),
		.status      (status_w),
		.sample_word (sample.payload),
		.out_ready   (result.ready),
		.out_valid   (result.valid),
		.out_word    (result_word),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	assign result.payload = result_word;

	// After a sample word is taken the controller is not ready in the next cycle.
	`IMC_ASSERT_NXT(a_busy_after_accept, sample.valid && sample.ready, !sample.ready, "sample taken while busy")

	// A new result is only written when the output register is free or being emptied.
	`IMC_ASSERT_IMP(a_commit_slot_free, cmd_w.commit, !result.valid || result.ready, "result overwritten")

	// The output register only fills through a commit.
	`IMC_ASSERT_IMP(a_valid_from_commit, $rose(result.valid), $past(cmd_w.commit), "result without commit")

	// Event codes stay within the defined set.
	`IMC_ASSERT_IMP(a_event_range, result.valid, result.payload.event_res <= EV_STILL, "bad event code")

endmodule

`default_nettype wire

@@ verif/imu_motion_event_classifier_tb.sv @@
// Self-checking testbench for the IMU motion event classifier. It drives sample words and
// configuration writes, and checks each result word against a built-in event predictor or
// a directed row's event. It depends on imc_pkg, imc_stream_if and the classifier RTL.
`timescale 1ns / 100ps

module imu_motion_event_classifier_tb;
	import imc_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 11;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 6;
	localparam int WORDS_PER_PHASE = 100;
	// Words at the end of the last phase that run with no idling on either side.
	localparam int CALM_WORDS = 40;
	// Cycles to wait after the last result word. This is more than one full sample latency.
	localparam int DRAIN_CYCLES = 80;

	// One directed stimulus row. Where typed is set, the expected event is given in the row.
	// Otherwise the predictor supplies the expected event.
	typedef struct {
		imc_sample_t word;
		bit          typed;
		logic [2:0]  ev;
	} probe_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	imc_stream_if #(.payload_t(imc_sample_t)) sample_if ();
	imc_stream_if #(.payload_t(imc_result_t)) result_if ();

	imu_motion_event_classifier u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_if),
		.result    (result_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Predictor copy of the configuration registers.
	logic [15:0] cfg_move;
	logic [15:0] cfg_shake;
	logic [15:0] cfg_pickup;
	logic [15:0] cfg_cool;
	logic [23:0] cfg_still;

	// Predictor copy of the classifier history.
	logic signed [15:0] prev_x;
	logic signed [15:0] prev_y;
	logic signed [15:0] prev_z;
	bit                 have_prev;
	logic [31:0]        last_motion;
	logic [31:0]        cool_until;
	bit                 still_done;

	logic [2:0] pending_events [$];
	int         mismatch_count = 0;
	int         cycle_count = 0;
	bit         calm = 1'b0;
	// This is the running millisecond clock of the well-formed random samples.
	logic [31:0] sample_ms = 32'd0;

	// Receiver stall pattern. The stall is either a low burst or a high run.
	int hold_left = 0;
	bit hold_low = 1'b0;

	// Floor square root. This builds the root one bit at a time from the top bit.
	function automatic logic [31:0] floor_root(longint unsigned v);
		logic [31:0]     r;
		longint unsigned t;
		r = '0;
		for (int b = 16; b >= 0; b--) begin
			t = longint'(r | (32'd1 << b));
			if (t * t <= v)
				r = t[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] vec_len(logic signed [15:0] a, logic signed [15:0] b,
			logic signed [15:0] c);
		longint la;
		longint lb;
		longint lc;
		la = a;
		lb = b;
		lc = c;
		return floor_root(longint'(la * la + lb * lb + lc * lc));
	endfunction

	function automatic logic [31:0] axis_gap(logic signed [15:0] a, logic signed [15:0] b);
		int d;
		d = int'(a) - int'(b);
		return (d < 0) ? -d : d;
	endfunction

	// Returns the event for one accepted sample and advances the predicted history.
	function automatic logic [2:0] classify_sample(imc_sample_t s);
		logic [31:0] amag;
		logic [31:0] gmag;
		logic [31:0] pmag;
		logic [31:0] mag_delta;
		logic [31:0] axis_delta;
		logic [31:0] axis_thr;
		logic [31:0] g_dev;
		logic [31:0] quiet;
		bit          moved;
		logic [2:0]  ev;

		// A restart drops the sample and clears the history. The timestamp becomes the
		// last motion time.
		if (s.restart) begin
			prev_x = '0;
			prev_y = '0;
			prev_z = '0;
			have_prev = 1'b0;
			last_motion = s.now_ms;
			cool_until = '0;
			still_done = 1'b0;
			return EV_NONE;
		end

		// The first sample after reset or restart only seeds the history.
		if (!have_prev) begin
			prev_x = s.accel_x;
			prev_y = s.accel_y;
			prev_z = s.accel_z;
			have_prev = 1'b1;
			last_motion = s.now_ms;
			return EV_NONE;
		end

		amag = vec_len(s.accel_x, s.accel_y, s.accel_z);
		gmag = vec_len(s.gyro_x, s.gyro_y, s.gyro_z);
		pmag = vec_len(prev_x, prev_y, prev_z);
		mag_delta = (amag >= pmag) ? amag - pmag : pmag - amag;
		axis_delta = axis_gap(s.accel_x, prev_x) + axis_gap(s.accel_y, prev_y) +
			axis_gap(s.accel_z, prev_z);
		axis_thr = (32'd9 * {16'd0, cfg_move}) / 32'd5;
		g_dev = (amag >= ONE_G_Q12) ? amag - ONE_G_Q12 : ONE_G_Q12 - amag;
		moved = (mag_delta >= cfg_move) || (axis_delta >= axis_thr);

		prev_x = s.accel_x;
		prev_y = s.accel_y;
		prev_z = s.accel_z;

		// Motion refreshes the quiet timer even when the event itself is suppressed.
		if (moved) begin
			last_motion = s.now_ms;
			still_done = 1'b0;
		end

		// The cooldown compare is a plain unsigned compare. A window that wraps past zero
		// therefore holds for the early part of the next epoch.
		ev = EV_NONE;
		quiet = s.now_ms - last_motion;
		if (s.now_ms < cool_until) begin
			ev = EV_NONE;
		end else if (gmag >= cfg_shake) begin
			cool_until = s.now_ms + cfg_cool;
			ev = EV_SHAKE;
		end else if (g_dev >= cfg_pickup) begin
			cool_until = s.now_ms + cfg_cool;
			ev = EV_PICKUP;
		end else if (moved) begin
			cool_until = s.now_ms + cfg_cool;
			ev = EV_MOTION;
		end else if (!still_done && quiet >= {8'd0, cfg_still}) begin
			still_done = 1'b1;
			ev = EV_STILL;
		end
		return ev;
	endfunction

	// Writes every register in index order and then the unused indexes, which must be
	// dropped. The 16-bit registers may get junk in their upper data bits, which must be
	// masked off.
	task automatic load_settings(input logic [23:0] v_move, input logic [23:0] v_shake,
			input logic [23:0] v_pickup, input logic [23:0] v_cool, input logic [23:0] v_still);
		logic [CFG_DATA_W-1:0] vals [1 << CFG_IDX_W];
		vals[REG_MOVE_DELTA] = v_move;
		vals[REG_SHAKE_GYRO] = v_shake;
		vals[REG_PICKUP_DELTA] = v_pickup;
		vals[REG_COOLDOWN_MS] = v_cool;
		vals[REG_STILL_MS] = v_still;
		for (int i = REG_STILL_MS + 1; i < (1 << CFG_IDX_W); i++)
			vals[i] = CFG_DATA_W'($urandom);
		for (int i = 0; i < (1 << CFG_IDX_W); i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cfg_move = v_move[15:0];
		cfg_shake = v_shake[15:0];
		cfg_pickup = v_pickup[15:0];
		cfg_cool = v_cool[15:0];
		cfg_still = v_still[23:0];
	endtask

	// A random sender gap, taken about one word in four while not calm.
	task automatic maybe_idle();
		if (!calm && $urandom_range(0, 3) == 0) begin
			sample_if.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Presents one sample word and holds it until the block takes it. Valid stays high
	// afterward so that a following word can go out back to back. The expected event is
	// queued at the moment the word is accepted.
	task automatic send_word(input imc_sample_t w, input bit typed, input logic [2:0] fixed_ev);
		logic [2:0] ev;
		sample_if.valid <= 1'b1;
		sample_if.payload <= w;
		@(posedge clk);
		while (!sample_if.ready)
			@(posedge clk);
		ev = classify_sample(w);
		pending_events.push_back(typed ? fixed_ev : ev);
	endtask

	function automatic probe_t probe(int ax, int ay, int az, int gx, int gy, int gz,
			logic [31:0] now, bit rs, bit typed, logic [2:0] ev);
		probe_t p;
		p.word.accel_x = 16'(ax);
		p.word.accel_y = 16'(ay);
		p.word.accel_z = 16'(az);
		p.word.gyro_x = 16'(gx);
		p.word.gyro_y = 16'(gy);
		p.word.gyro_z = 16'(gz);
		p.word.now_ms = now;
		p.word.restart = rs;
		p.typed = typed;
		p.ev = ev;
		return p;
	endfunction

	function automatic int jitter(int amp);
		return int'($urandom_range(0, 2 * amp)) - amp;
	endfunction

	// Random sample generator. Most words are a device resting near 1 g with small noise
	// and a time that moves forward, so that the history, the cooldown and the quiet timer
	// are exercised. The other words are restarts, large jolts, quiet gaps long enough for
	// a still-long event, time jumps, and fully random noise.
	function automatic imc_sample_t draw_sample();
		imc_sample_t w;
		int unsigned kind;
		int unsigned step;
		int          amp;
		kind = $urandom_range(0, 99);
		w = '0;
		if (kind < 16) begin
			w.accel_x = 16'($urandom);
			w.accel_y = 16'($urandom);
			w.accel_z = 16'($urandom);
			w.gyro_x = 16'($urandom);
			w.gyro_y = 16'($urandom);
			w.gyro_z = 16'($urandom);
			// Restarts take the running clock. Noise words take any time at all.
			w.restart = (kind < 4);
			w.now_ms = w.restart ? sample_ms : $urandom;
			return w;
		end

		step = $urandom_range(0, 99);
		if (step < 3)
			sample_ms = $urandom;
		else if (step < 9)
			sample_ms = sample_ms + {8'd0, cfg_still} + $urandom_range(0, 3);
		else
			sample_ms = sample_ms + $urandom_range(1, 60);

		amp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1500) : $urandom_range(0, 40);
		w.accel_x = 16'(jitter(amp));
		w.accel_y = 16'(jitter(amp));
		w.accel_z = 16'(($urandom_range(0, 1) ? 4096 : -4096) + jitter(amp));
		if ($urandom_range(0, 11) == 0)
			w.accel_z = 16'($urandom_range(0, 12000));
		w.gyro_x = 16'(jitter(300));
		w.gyro_y = 16'(jitter(300));
		w.gyro_z = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(jitter(300));
		w.now_ms = sample_ms;
		w.restart = 1'b0;
		return w;
	endfunction

	// Result checker and receiver stall pattern. Both look at the values present at the
	// clock edge. The new ready value is applied after the edge.
	always @(posedge clk) begin
		logic [2:0] want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_events.size() == 0) begin
				$error("unexpected result word: event_res %0d", result_if.payload.event_res);
				mismatch_count++;
			end else begin
				want = pending_events.pop_front();
				if (result_if.payload.event_res !== want) begin
					$error("event_res mismatch: expected %0d, actual %0d", want,
						result_if.payload.event_res);
					mismatch_count++;
				end
			end
		end
		if (calm) begin
			result_if.ready <= 1'b1;
		end else begin
			if (hold_left == 0) begin
				hold_low = ($urandom_range(0, 2) == 0);
				hold_left = hold_low ? $urandom_range(1, 14) : $urandom_range(1, 40);
			end
			hold_left--;
			result_if.ready <= !hold_low;
		end
	end

	// Watchdog. The slowest correct run is about 620 words. The limit is several times the
	// length of that run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("imu_motion_event_classifier_tb: errors");
			$finish;
		end
	end

	initial begin
		probe_t plan [$];

		sample_if.valid <= 1'b0;
		sample_if.payload <= '0;

		// These are the predictor's register values after reset.
		cfg_move = RST_MOVE_DELTA;
		cfg_shake = RST_SHAKE_GYRO;
		cfg_pickup = RST_PICKUP_DELTA;
		cfg_cool = RST_COOLDOWN_MS;
		cfg_still = RST_STILL_MS;
		prev_x = '0;
		prev_y = '0;
		prev_z = '0;
		have_prev = 1'b0;
		last_motion = '0;
		cool_until = '0;
		still_done = 1'b0;

		// Directed part. It runs on the register values after reset. The comments give the
		// intent of each row.
		// First sample after reset: it is only stored.
		plan.push_back(probe(0, 0, 4096, 0, 0, 0, 32'd100, 1'b0, 1'b1, EV_NONE));
		// Same sample again: nothing moved and the quiet time is still short.
		plan.push_back(probe(0, 0, 4096, 0, 0, 0, 32'd200, 1'b0, 1'b0, EV_NONE));
		// Gyro at full scale gives a shake and opens a cooldown until 1100.
		plan.push_back(probe(0, 0, 4096, 32767, -32768, 32767, 32'd300, 1'b0, 1'b1, EV_SHAKE));
		// Accel at negative full scale moves a lot, but the cooldown hides it.
		plan.push_back(probe(-32768, -32768, -32768, 0, 0, 0, 32'd400, 1'b0, 1'b1, EV_NONE));
		// Last millisecond of the cooldown: everything at positive full scale is still hidden.
		plan.push_back(probe(32767, 32767, 32767, -32768, -32768, -32768, 32'd1099, 1'b0, 1'b1,
			EV_NONE));
		// The cooldown ends exactly here. The large drop in magnitude is motion.
		plan.push_back(probe(0, 0, 4096, 0, 0, 0, 32'd1100, 1'b0, 1'b0, EV_NONE));
		// Departure from 1 g exactly at the pickup threshold.
		plan.push_back(probe(0, 0, 5325, 100, -100, 50, 32'd1900, 1'b0, 1'b0, EV_NONE));
		// Restart: the accel and gyro fields are ignored.
		plan.push_back(probe(32767, -32768, 32767, -32768, 32767, -32768, 32'd5000, 1'b1, 1'b1,
			EV_NONE));
		// First sample after the restart.
		plan.push_back(probe(0, 4096, 0, 0, 0, 0, 32'd5010, 1'b0, 1'b1, EV_NONE));
		// Tiny wobble, well below both motion thresholds.
		plan.push_back(probe(1, 4095, -1, 0, 0, 0, 32'd6000, 1'b0, 1'b0, EV_NONE));
		// Quiet for exactly the still time: one still-long event.
		plan.push_back(probe(0, 4096, 0, 0, 0, 0, 32'd65010, 1'b0, 1'b0, EV_NONE));
		// Still quiet, but the still-long event was already reported.
		plan.push_back(probe(0, 4096, 0, 0, 0, 0, 32'd70000, 1'b0, 1'b0, EV_NONE));
		// Shake just before the time wraps. The cooldown end wraps to 0x310.
		plan.push_back(probe(0, 4096, 0, 0, 0, 8192, 32'hFFFF_FFF0, 1'b0, 1'b0, EV_NONE));
		// After the wrap, the plain compare still sees the cooldown.
		plan.push_back(probe(0, 4096, 0, 0, 0, -32768, 32'h0000_0100, 1'b0, 1'b1, EV_NONE));
		// The wrapped cooldown ends. Gyro magnitude exactly at the threshold.
		plan.push_back(probe(0, 4096, 0, 0, 0, -8192, 32'h0000_0310, 1'b0, 1'b1, EV_SHAKE));
		// Gyro one count below the threshold.
		plan.push_back(probe(0, 4096, 0, 0, 0, 8191, 32'h0000_0700, 1'b0, 1'b0, EV_NONE));
		// Magnitude change one below the motion threshold.
		plan.push_back(probe(0, 4423, 0, 0, 0, 0, 32'h0000_0800, 1'b0, 1'b0, EV_NONE));
		// Magnitude change exactly at the motion threshold.
		plan.push_back(probe(0, 4751, 0, 0, 0, 0, 32'h0000_0900, 1'b0, 1'b0, EV_NONE));
		// Per-axis change sum exactly at floor(9 * 328 / 5) while the magnitude barely moves.
		plan.push_back(probe(295, 4751, -295, 0, 0, 0, 32'h0000_0D00, 1'b0, 1'b0, EV_NONE));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			maybe_idle();
			send_word(plan[i].word, plan[i].typed, plan[i].ev);
		end
		sample_ms = 32'h0000_1000;

		for (int ph = 0; ph < PHASES; ph++) begin
			// Registers change only once every result word of the previous phase is in.
			// No sample is in work at that point.
			case (ph)
				1: load_settings(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
				2: load_settings(24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 24'hFFFFFF);
				3: load_settings({8'($urandom), RST_MOVE_DELTA}, {8'($urandom), RST_SHAKE_GYRO},
					{8'($urandom), RST_PICKUP_DELTA}, {8'($urandom), RST_COOLDOWN_MS},
					RST_STILL_MS);
				4, 5: load_settings({8'($urandom), 16'($urandom_range(0, 2000))},
					{8'($urandom), 16'($urandom_range(0, 20000))},
					{8'($urandom), 16'($urandom_range(0, 3000))},
					{8'($urandom), 16'($urandom_range(0, 2000))},
					24'($urandom_range(0, 5000)));
				default: ;
			endcase
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				calm = (ph == PHASES - 1) && (n >= WORDS_PER_PHASE - CALM_WORDS);
				maybe_idle();
				send_word(draw_sample(), 1'b0, EV_NONE);
			end
			sample_ms = sample_ms + $urandom_range(1, 60);
			sample_if.valid <= 1'b0;
			while (pending_events.size() != 0)
				@(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_events.size() == 0)
			$display("imu_motion_event_classifier_tb: clean");
		else
			$display("imu_motion_event_classifier_tb: errors");
		$finish;
	end

endmodule
